// ----- rtl/aes256_ctr_xor_counter_stream_core_assert.svh -----
// Assertion macros for the stream core top level
`ifndef AES256_CTR_XOR_COUNTER_STREAM_CORE_ASSERT_SVH
`define AES256_CTR_XOR_COUNTER_STREAM_CORE_ASSERT_SVH

// same-cycle implication, checked out of reset
`define ACTR_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked out of reset
`define ACTR_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/actr_pkg.sv -----
// Shared types, constants and AES helper functions for the CTR stream core
`timescale 1ns / 1ps
package actr_pkg;

  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned NUM_ROUNDS  = 14;
  localparam int unsigned CFG_IDX_W   = 8;

  localparam logic [CFG_IDX_W-1:0] REG_KEY0     = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_KEY1     = 8'd1;
  localparam logic [CFG_IDX_W-1:0] REG_KEY2     = 8'd2;
  localparam logic [CFG_IDX_W-1:0] REG_KEY3     = 8'd3;
  localparam logic [CFG_IDX_W-1:0] REG_SALT_HI  = 8'd4;
  localparam logic [CFG_IDX_W-1:0] REG_SALT_LO  = 8'd5;
  localparam logic [CFG_IDX_W-1:0] REG_PUB_HI   = 8'd6;
  localparam logic [CFG_IDX_W-1:0] REG_PUB_LO   = 8'd7;

  localparam logic [2047:0] SBOX_TBL = {
    128'h637c777bf26b6fc53001672bfed7ab76, 128'hca82c97dfa5947f0add4a2af9ca472c0,
    128'hb7fd9326363ff7cc34a5e5f171d83115, 128'h04c723c31896059a071280e2eb27b275,
    128'h09832c1a1b6e5aa0523bd6b329e32f84, 128'h53d100ed20fcb15b6acbbe394a4c58cf,
    128'hd0efaafb434d338545f9027f503c9fa8, 128'h51a3408f929d38f5bcb6da2110fff3d2,
    128'hcd0c13ec5f974417c4a77e3d645d1973, 128'h60814fdc222a908846eeb814de5e0bdb,
    128'he0323a0a4906245cc2d3ac629195e479, 128'he7c8376d8dd54ea96c56f4ea657aae08,
    128'hba78252e1ca6b4c6e8dd741f4bbd8b8a, 128'h703eb5664803f60e613557b986c11d9e,
    128'he1f8981169d98e949b1e87e9ce5528df, 128'h8ca1890dbfe6426841992d0fb054bb16
  };

  // queued item: byte, its place in the keystream block, restart flag
  typedef struct packed {
    logic [7:0] data;
    logic [3:0] pos;
    logic       restart;
  } actr_item_t;

  typedef struct packed {
    logic empty;
    logic full;
  } actr_q_status_t;

  typedef struct packed {
    logic start;
    logic abort;
  } actr_aes_ctrl_t;

  typedef struct packed {
    logic busy;
    logic done;
  } actr_aes_status_t;

  function automatic logic [7:0] sbox(input logic [7:0] b);
    logic [2047:0] tmp;
    tmp = SBOX_TBL >> {~b, 3'b000};
    return tmp[7:0];
  endfunction

  function automatic logic [7:0] xtime(input logic [7:0] b);
    return {b[6:0], 1'b0} ^ (b[7] ? 8'h1b : 8'h00);
  endfunction

  // byte idx of a 128-bit block, byte 0 in the top bits
  function automatic logic [7:0] get_byte(input logic [127:0] v, input logic [3:0] idx);
    logic [127:0] tmp;
    tmp = v >> {~idx, 3'b000};
    return tmp[7:0];
  endfunction

  // slides the 8-word key window on by four words
  function automatic logic [255:0] key_next(input logic [255:0] k, input logic rot,
                                            input logic [7:0] rcon);
    logic [31:0] w7, t, n0, n1, n2, n3;
    w7 = k[31:0];
    if (rot) begin
      t = {sbox(w7[23:16]) ^ rcon, sbox(w7[15:8]), sbox(w7[7:0]), sbox(w7[31:24])};
    end else begin
      t = {sbox(w7[31:24]), sbox(w7[23:16]), sbox(w7[15:8]), sbox(w7[7:0])};
    end
    n0 = k[255:224] ^ t;
    n1 = k[223:192] ^ n0;
    n2 = k[191:160] ^ n1;
    n3 = k[159:128] ^ n2;
    return {k[127:0], n0, n1, n2, n3};
  endfunction

  // SubBytes, ShiftRows, MixColumns (skipped on the last round), AddRoundKey
  function automatic logic [127:0] enc_round(input logic [127:0] s, input logic [127:0] rk,
                                             input logic last);
    logic [7:0]   t [16];
    logic [127:0] o;
    logic [7:0]   a0, a1, a2, a3, al;
    for (int r = 0; r < 4; r++) begin
      for (int c = 0; c < 4; c++) begin
        t[r + 4 * c] = get_byte(s, 4'((r + 4 * ((c + r) & 3))));
      end
    end
    for (int i = 0; i < 16; i++) begin
      t[i] = sbox(t[i]);
    end
    for (int c = 0; c < 4; c++) begin
      a0 = t[4 * c];
      a1 = t[4 * c + 1];
      a2 = t[4 * c + 2];
      a3 = t[4 * c + 3];
      al = a0 ^ a1 ^ a2 ^ a3;
      if (!last) begin
        a0 = t[4 * c] ^ al ^ xtime(t[4 * c] ^ t[4 * c + 1]);
        a1 = t[4 * c + 1] ^ al ^ xtime(t[4 * c + 1] ^ t[4 * c + 2]);
        a2 = t[4 * c + 2] ^ al ^ xtime(t[4 * c + 2] ^ t[4 * c + 3]);
        a3 = t[4 * c + 3] ^ al ^ xtime(t[4 * c + 3] ^ t[4 * c]);
      end
      o[127 - 32 * c -: 32] = {a0, a1, a2, a3};
    end
    return o ^ rk;
  endfunction

endpackage

// ----- rtl/actr_front.sv -----
// Front end: accepts bytes and tags each with its keystream position
`timescale 1ns / 1ps
module actr_front (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_tvalid,
  output logic                in_tready,
  input  logic [7:0]          in_tdata,   // data_byte
  input  logic                in_tuser,   // message_start
  input  logic                q_full,
  output logic                q_push,
  output actr_pkg::actr_item_t q_item
);

  logic [3:0] pos_r, pos_nxt;
  logic [3:0] cur_pos;

  assign in_tready = !q_full;
  assign q_push    = in_tvalid && in_tready;
  assign cur_pos   = in_tuser ? 4'd0 : pos_r;
  assign pos_nxt   = cur_pos + 4'd1;

  assign q_item.data    = in_tdata;
  assign q_item.pos     = cur_pos;
  assign q_item.restart = in_tuser;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r <= 4'd0;
    end else if (q_push) begin
      pos_r <= pos_nxt;
    end
  end

endmodule

// ----- rtl/actr_queue.sv -----
// Small FIFO between the front end and the keystream back end
`timescale 1ns / 1ps
module actr_queue #(
  parameter int unsigned DEPTH = actr_pkg::QUEUE_DEPTH
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   push,
  input  actr_pkg::actr_item_t   push_item,
  input  logic                   pop,
  output actr_pkg::actr_item_t   head,
  output actr_pkg::actr_q_status_t status
);

  localparam int unsigned PTR_W = $clog2(DEPTH);
  localparam int unsigned CNT_W = PTR_W + 1;

  actr_pkg::actr_item_t mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt, rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             do_push, do_pop;

  assign status.empty = (count_r == '0);
  assign status.full  = (count_r == CNT_W'(DEPTH));
  assign do_push      = push && !status.full;
  assign do_pop       = pop && !status.empty;
  assign head         = mem[rd_ptr_r];

  assign wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
  assign rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;

  always_comb begin
    count_nxt = count_r;
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr_r] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= wr_ptr_nxt;
      end
      if (do_pop) begin
        rd_ptr_r <= rd_ptr_nxt;
      end
      count_r <= count_nxt;
    end
  end

endmodule

// ----- rtl/actr_aes.sv -----
// Iterative AES-256 encryptor, one round per cycle, key schedule on the fly
`timescale 1ns / 1ps
module actr_aes (
  input  logic                      clk,
  input  logic                      rst_n,
  input  actr_pkg::actr_aes_ctrl_t  ctrl,
  input  logic [255:0]              key,
  input  logic [127:0]              blk,
  output actr_pkg::actr_aes_status_t status,
  output logic [127:0]              result
);

  logic         busy_r, done_r;
  logic [3:0]   rnd_r;
  logic [127:0] s_r;
  logic [255:0] k_r;
  logic         rot_r;
  logic [7:0]   rcon_r;
  logic         last;

  assign last          = (rnd_r == 4'(actr_pkg::NUM_ROUNDS));
  assign status.busy   = busy_r;
  assign status.done   = done_r;
  assign result        = s_r;

  always_ff @(posedge clk) begin
    if (ctrl.start) begin
      s_r    <= blk ^ key[255:128];
      k_r    <= actr_pkg::key_next(key, 1'b1, 8'h01);
      rot_r  <= 1'b0;
      rcon_r <= 8'h02;
    end else if (busy_r) begin
      s_r   <= actr_pkg::enc_round(s_r, k_r[255:128], last);
      k_r   <= actr_pkg::key_next(k_r, rot_r, rcon_r);
      rot_r <= ~rot_r;
      if (rot_r) begin
        rcon_r <= actr_pkg::xtime(rcon_r);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      rnd_r  <= 4'd0;
    end else if (ctrl.abort) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else if (ctrl.start) begin
      busy_r <= 1'b1;
      done_r <= 1'b0;
      rnd_r  <= 4'd1;
    end else begin
      done_r <= busy_r && last;
      if (busy_r) begin
        rnd_r <= rnd_r + 4'd1;
        if (last) begin
          busy_r <= 1'b0;
        end
      end
    end
  end

endmodule

// ----- rtl/actr_back.sv -----
// Back end: keystream prefetch, counter tracking and output register
`timescale 1ns / 1ps
module actr_back (
  input  logic                      clk,
  input  logic                      rst_n,
  input  actr_pkg::actr_item_t      head,
  input  logic                      q_empty,
  output logic                      q_pop,
  input  logic [127:0]              iv,
  input  logic                      cfg_wr,
  output actr_pkg::actr_aes_ctrl_t  aes_ctrl,
  output logic [127:0]              aes_blk,
  input  actr_pkg::actr_aes_status_t aes_st,
  input  logic [127:0]              aes_result,
  output logic                      out_tvalid,
  input  logic                      out_tready,
  output logic [7:0]                out_tdata    // out_byte
);

  logic [127:0] cur_ks_r, nxt_ks_r, ks;
  logic         nxt_v_r;
  logic [31:0]  req_ctr_r, start_ctr;
  logic         out_valid_r;
  logic [7:0]   out_data_r;
  logic         adv, head_new, flush, ks_ok, consume_new;

  assign adv      = !out_valid_r || out_tready;
  assign head_new = (head.pos == 4'd0);
  // restart only needs a flush if the prefetch is not already on counter 0
  assign flush    = !q_empty && head.restart && (req_ctr_r != 32'd0);
  assign ks_ok    = !head_new || nxt_v_r;
  assign q_pop    = !q_empty && adv && ks_ok && !flush;
  assign consume_new = q_pop && head_new;

  assign aes_ctrl.abort = cfg_wr || flush;
  assign aes_ctrl.start = !aes_ctrl.abort && !aes_st.busy && !aes_st.done &&
                          (!nxt_v_r || consume_new);
  assign start_ctr = consume_new ? req_ctr_r + 32'd1 : req_ctr_r;
  assign aes_blk   = iv ^ {96'd0, start_ctr};

  assign ks         = head_new ? nxt_ks_r : cur_ks_r;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  always_ff @(posedge clk) begin
    if (q_pop) begin
      out_data_r <= head.data ^ actr_pkg::get_byte(ks, head.pos);
    end
    if (consume_new) begin
      cur_ks_r <= nxt_ks_r;
    end
    if (aes_st.done) begin
      nxt_ks_r <= aes_result;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      nxt_v_r     <= 1'b0;
      req_ctr_r   <= 32'd0;
    end else begin
      if (q_pop) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
      if (aes_ctrl.abort || consume_new) begin
        nxt_v_r <= 1'b0;
      end else if (aes_st.done) begin
        nxt_v_r <= 1'b1;
      end
      if (flush) begin
        req_ctr_r <= 32'd0;
      end else if (consume_new) begin
        req_ctr_r <= req_ctr_r + 32'd1;
      end
    end
  end

endmodule

// ----- rtl/aes256_ctr_xor_counter_stream_core.sv -----
// Top level of the AES-256 CTR byte stream core
//
// Byte in, byte out: each in_ transaction carries one data byte (in_tdata) and a
// message-start flag (in_tuser); each out_ transaction returns that byte XORed
// with the next AES-256 counter-mode keystream byte, in order, one per input.
// Key quarters and IV halves are written through the cfg_ channel (index 0..7),
// only while the stream is idle: a rule for the user, not enforced by the block;
// out-of-range indexes are dropped. Each byte passes through a queue entry and
// the output register. Throughput is one byte per cycle while the receiver is
// ready: a round-iterative AES unit builds the next counter block while the
// current 16 bytes are consumed. A message start whose counter is not already
// zero flushes the prefetch and waits for a fresh block before its first byte;
// a config write also drops the prefetch. Reset (rst_n low, synchronous) clears
// config, counter, position and valid flags. A stalled receiver holds the output
// register; the 4-entry queue takes bytes until full, then in_tready drops.
`timescale 1ns / 1ps
module aes256_ctr_xor_counter_stream_core #(
  parameter int unsigned QUEUE_DEPTH = actr_pkg::QUEUE_DEPTH
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  input  logic [7:0]                        in_tdata,   // data_byte
  input  logic                              in_tuser,   // message_start
  output logic                              out_tvalid,
  input  logic                              out_tready,
  output logic [7:0]                        out_tdata,  // out_byte
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [actr_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [63:0]                       cfg_data
);

  `include "aes256_ctr_xor_counter_stream_core_assert.svh"

  logic [63:0] key0_r, key1_r, key2_r, key3_r;
  logic [63:0] salt_hi_r, salt_lo_r, pub_hi_r, pub_lo_r;
  logic        cfg_wr;

  actr_pkg::actr_item_t       q_item, q_head;
  actr_pkg::actr_q_status_t   q_st;
  logic                       q_push, q_pop;
  actr_pkg::actr_aes_ctrl_t   aes_ctrl;
  actr_pkg::actr_aes_status_t aes_st;
  logic [127:0]               aes_blk, aes_result, iv;
  logic [255:0]               key;

  assign cfg_ready = 1'b1;
  assign cfg_wr    = cfg_valid && cfg_ready;
  assign key       = {key0_r, key1_r, key2_r, key3_r};
  assign iv        = {salt_hi_r ^ pub_hi_r, salt_lo_r ^ pub_lo_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key0_r    <= '0;
      key1_r    <= '0;
      key2_r    <= '0;
      key3_r    <= '0;
      salt_hi_r <= '0;
      salt_lo_r <= '0;
      pub_hi_r  <= '0;
      pub_lo_r  <= '0;
    end else if (cfg_wr) begin
      unique case (cfg_index)
        actr_pkg::REG_KEY0:    key0_r    <= cfg_data;
        actr_pkg::REG_KEY1:    key1_r    <= cfg_data;
        actr_pkg::REG_KEY2:    key2_r    <= cfg_data;
        actr_pkg::REG_KEY3:    key3_r    <= cfg_data;
        actr_pkg::REG_SALT_HI: salt_hi_r <= cfg_data;
        actr_pkg::REG_SALT_LO: salt_lo_r <= cfg_data;
        actr_pkg::REG_PUB_HI:  pub_hi_r  <= cfg_data;
        actr_pkg::REG_PUB_LO:  pub_lo_r  <= cfg_data;
        default: ;
      endcase
    end
  end

  actr_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .q_full    (q_st.full),
    .q_push    (q_push),
    .q_item    (q_item)
  );

  actr_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_item (q_item),
    .pop       (q_pop),
    .head      (q_head),
    .status    (q_st)
  );

  actr_aes u_aes (
    .clk    (clk),
    .rst_n  (rst_n),
    .ctrl   (aes_ctrl),
    .key    (key),
    .blk    (aes_blk),
    .status (aes_st),
    .result (aes_result)
  );

  actr_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head       (q_head),
    .q_empty    (q_st.empty),
    .q_pop      (q_pop),
    .iv         (iv),
    .cfg_wr     (cfg_wr),
    .aes_ctrl   (aes_ctrl),
    .aes_blk    (aes_blk),
    .aes_st     (aes_st),
    .aes_result (aes_result),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  `ACTR_ASSERT_NEXT(a_push_lands, in_tvalid && in_tready, !q_st.empty, "accepted byte not queued")
  `ACTR_ASSERT_IMPL(a_out_from_queue, $rose(out_tvalid), $past(!q_st.empty), "output without queued byte")
  `ACTR_ASSERT_IMPL(a_start_idle, aes_ctrl.start, !aes_st.busy && !aes_ctrl.abort, "AES restarted while busy")

endmodule

// ----- dv/tb_aes256_ctr_xor_counter_stream_core.sv -----
// Testbench for the AES-256 CTR byte stream core: directed table then random phases
`timescale 1ns / 1ps
module tb_aes256_ctr_xor_counter_stream_core;

  localparam int unsigned CYCLE_LIMIT = 2000000;
  localparam int unsigned ITEMS_PER_PHASE = 150;

  localparam logic [2047:0] SUBST = {
    128'h637c777bf26b6fc53001672bfed7ab76, 128'hca82c97dfa5947f0add4a2af9ca472c0,
    128'hb7fd9326363ff7cc34a5e5f171d83115, 128'h04c723c31896059a071280e2eb27b275,
    128'h09832c1a1b6e5aa0523bd6b329e32f84, 128'h53d100ed20fcb15b6acbbe394a4c58cf,
    128'hd0efaafb434d338545f9027f503c9fa8, 128'h51a3408f929d38f5bcb6da2110fff3d2,
    128'hcd0c13ec5f974417c4a77e3d645d1973, 128'h60814fdc222a908846eeb814de5e0bdb,
    128'he0323a0a4906245cc2d3ac629195e479, 128'he7c8376d8dd54ea96c56f4ea657aae08,
    128'hba78252e1ca6b4c6e8dd741f4bbd8b8a, 128'h703eb5664803f60e613557b986c11d9e,
    128'he1f8981169d98e949b1e87e9ce5528df, 128'h8ca1890dbfe6426841992d0fb054bb16
  };

  typedef struct {
    logic [7:0] data;
    bit         start;
    bit         typed;
    logic [7:0] want;
  } stim_row_t;

  typedef struct {
    logic [7:0] byte_val;
    bit         typed;
    logic [7:0] typed_val;
  } expected_byte_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata = 8'h00;   // data_byte
  logic        in_tuser = 1'b0;    // message_start
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [7:0]  out_tdata;          // out_byte
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [actr_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [63:0] cfg_data = '0;

  // predictor state
  logic [63:0]  key_iv_regs [8];
  logic [31:0]  blk_count;
  logic [3:0]   blk_pos;
  logic [127:0] ks_block;

  expected_byte_t out_expected [$];
  int unsigned errors = 0;
  int unsigned cycles = 0;
  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned hold_req = 0;
  int unsigned hold_seen = 0;
  int unsigned hold_left = 0;
  bit          cur_typed = 1'b0;
  logic [7:0]  cur_want = 8'h00;
  stim_row_t   rows [$];

  aes256_ctr_xor_counter_stream_core uut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  function automatic logic [7:0] subst(input logic [7:0] b);
    return SUBST[(255 - b) * 8 +: 8];
  endfunction

  function automatic logic [7:0] dbl(input logic [7:0] b);
    return {b[6:0], 1'b0} ^ (b[7] ? 8'h1b : 8'h00);
  endfunction

  // AES-256 of one block, byte 0 in the top bits of key and block
  function automatic logic [127:0] aes256_block(input logic [255:0] key, input logic [127:0] pt);
    logic [7:0] rk [240];
    logic [7:0] st [16];
    logic [7:0] sh [16];
    logic [7:0] w [4];
    logic [7:0] u, a0, a1, a2, a3, al;
    logic [127:0] res;
    for (int i = 0; i < 32; i++) rk[i] = key[255 - 8 * i -: 8];
    for (int i = 8; i < 60; i++) begin
      for (int j = 0; j < 4; j++) w[j] = rk[4 * (i - 1) + j];
      if (i % 8 == 0) begin
        u = w[0];
        w[0] = subst(w[1]) ^ (8'h01 << (i / 8 - 1));
        w[1] = subst(w[2]);
        w[2] = subst(w[3]);
        w[3] = subst(u);
      end else if (i % 8 == 4) begin
        for (int j = 0; j < 4; j++) w[j] = subst(w[j]);
      end
      for (int j = 0; j < 4; j++) rk[4 * i + j] = rk[4 * (i - 8) + j] ^ w[j];
    end
    for (int i = 0; i < 16; i++) st[i] = pt[127 - 8 * i -: 8] ^ rk[i];
    for (int rnd = 1; rnd <= 14; rnd++) begin
      for (int r = 0; r < 4; r++)
        for (int c = 0; c < 4; c++) sh[r + 4 * c] = subst(st[r + 4 * ((c + r) & 3)]);
      for (int c = 0; c < 4; c++) begin
        a0 = sh[4 * c]; a1 = sh[4 * c + 1]; a2 = sh[4 * c + 2]; a3 = sh[4 * c + 3];
        al = a0 ^ a1 ^ a2 ^ a3;
        if (rnd != 14) begin
          st[4 * c]     = a0 ^ al ^ dbl(a0 ^ a1);
          st[4 * c + 1] = a1 ^ al ^ dbl(a1 ^ a2);
          st[4 * c + 2] = a2 ^ al ^ dbl(a2 ^ a3);
          st[4 * c + 3] = a3 ^ al ^ dbl(a3 ^ a0);
        end else begin
          st[4 * c] = a0; st[4 * c + 1] = a1; st[4 * c + 2] = a2; st[4 * c + 3] = a3;
        end
      end
      for (int i = 0; i < 16; i++) st[i] = st[i] ^ rk[16 * rnd + i];
    end
    for (int i = 0; i < 16; i++) res[127 - 8 * i -: 8] = st[i];
    return res;
  endfunction

  function automatic logic [7:0] keystream_xor(input logic [7:0] d, input bit msg_start);
    logic [127:0] ctr_blk;
    logic [7:0]   o;
    if (msg_start) begin
      blk_count = '0;
      blk_pos = '0;
    end
    if (blk_pos == 4'd0) begin
      ctr_blk = {key_iv_regs[actr_pkg::REG_SALT_HI], key_iv_regs[actr_pkg::REG_SALT_LO]}
              ^ {key_iv_regs[actr_pkg::REG_PUB_HI], key_iv_regs[actr_pkg::REG_PUB_LO]};
      ctr_blk[31:0] = ctr_blk[31:0] ^ blk_count;
      ks_block = aes256_block({key_iv_regs[actr_pkg::REG_KEY0], key_iv_regs[actr_pkg::REG_KEY1],
                               key_iv_regs[actr_pkg::REG_KEY2], key_iv_regs[actr_pkg::REG_KEY3]},
                              ctr_blk);
      blk_count = blk_count + 32'd1;
    end
    o = d ^ ks_block[127 - 8 * blk_pos -: 8];
    blk_pos = blk_pos + 4'd1;
    return o;
  endfunction

  // both channels are stable from the falling edge up to the rising edge that moves them
  always @(negedge clk) begin
    expected_byte_t e;
    if (rst_n) begin
      if (in_tvalid && in_tready) begin
        e.byte_val = keystream_xor(in_tdata, in_tuser);
        e.typed = cur_typed;
        e.typed_val = cur_want;
        out_expected.push_back(e);
      end
      if (out_tvalid && out_tready) begin
        if (out_expected.size() == 0) begin
          errors++;
          $display("%0t: unexpected output transaction, actual %02h", $time, out_tdata);
        end else begin
          e = out_expected.pop_front();
          if (out_tdata !== e.byte_val || (e.typed && out_tdata !== e.typed_val)) begin
            errors++;
            $display("%0t: out_byte mismatch, expected %02h (table %02h), actual %02h",
                     $time, e.byte_val, e.typed ? e.typed_val : e.byte_val, out_tdata);
          end
        end
      end
    end
  end

  // receiver: random stalls plus a long hold-off on request
  always @(posedge clk) begin
    if (hold_req != hold_seen) begin
      hold_seen = hold_req;
      hold_left = 400;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  task automatic send_byte(input logic [7:0] d, input bit st, input bit typed,
                           input logic [7:0] want);
    bit acc;
    in_tvalid <= 1'b1;
    in_tdata <= d;
    in_tuser <= st;
    cur_typed = typed;
    cur_want = want;
    do begin
      @(negedge clk);
      acc = in_tready;
      @(posedge clk);
    end while (!acc);
    if ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
  endtask

  task automatic write_reg(input logic [actr_pkg::CFG_IDX_W-1:0] idx, input logic [63:0] val);
    bit acc;
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do begin
      @(negedge clk);
      acc = cfg_ready;
      @(posedge clk);
    end while (!acc);
    cfg_valid <= 1'b0;
    if (idx < 8) key_iv_regs[idx] = val;
    @(posedge clk);
  endtask

  // stop sending, let every result out, then give any prefetch time to settle
  task automatic drain;
    in_tvalid <= 1'b0;
    cur_typed = 1'b0;
    while (out_expected.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  function automatic logic [63:0] rand64;
    return {$urandom, $urandom};
  endfunction

  initial begin
    logic [63:0] v;
    for (int i = 0; i < 8; i++) key_iv_regs[i] = '0;
    blk_count = '0;
    blk_pos = '0;
    ks_block = '0;

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // zero key and IV: first block is the AES-256 all-zero vector dc95c078...
    rows.push_back('{8'h00, 1'b1, 1'b1, 8'hdc});
    rows.push_back('{8'hff, 1'b0, 1'b1, 8'h6a});
    rows.push_back('{8'h00, 1'b0, 1'b1, 8'hc0});
    rows.push_back('{8'hff, 1'b0, 1'b1, 8'h87});
    for (int i = 4; i < 16; i++) rows.push_back('{8'(i * 17), 1'b0, 1'b0, 8'h00});
    // block boundary with counter 1, then a restart mid-block
    rows.push_back('{8'h80, 1'b0, 1'b0, 8'h00});
    rows.push_back('{8'h01, 1'b0, 1'b0, 8'h00});
    rows.push_back('{8'h00, 1'b1, 1'b1, 8'hdc});
    rows.push_back('{8'h55, 1'b0, 1'b0, 8'h00});
    rows.push_back('{8'haa, 1'b1, 1'b1, 8'h76});
    foreach (rows[i]) send_byte(rows[i].data, rows[i].start, rows[i].typed, rows[i].want);
    drain();

    for (int ph = 0; ph < 4; ph++) begin
      for (int r = 0; r < 8; r++) begin
        case (ph)
          1: v = '1;
          3: v = (r < 4) ? 64'h0 : rand64();
          default: v = rand64();
        endcase
        write_reg(r[actr_pkg::CFG_IDX_W-1:0], v);
      end
      // indexes past the register file are dropped
      if (ph == 2) begin
        write_reg(8'd8, rand64());
        write_reg(8'hff, '1);
      end
      case (ph)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 47; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 47; hold_req++; end
        default: begin send_idle_pct = 34; recv_stall_pct = 34; end
      endcase
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        send_byte(8'($urandom), ($urandom_range(29) == 0) || (n == 0), 1'b0, 8'h00);
      end
      drain();
    end

    recv_stall_pct = 0;
    if (errors == 0 && out_expected.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
+incdir+rtl
rtl/actr_pkg.sv
rtl/actr_front.sv
rtl/actr_queue.sv
rtl/actr_aes.sv
rtl/actr_back.sv
rtl/aes256_ctr_xor_counter_stream_core.sv
dv/tb_aes256_ctr_xor_counter_stream_core.sv
